/* hdl/sdofr_pkg.sv */
// Shared types, constants and the product schedule for the oscillator response block.
// Used by sdofr_mac, sdofr_scale, sdofr_ctrl and sdof_oscillator_response_peaks.
// No dependencies.
package sdofr_pkg;

  localparam int COEF_W     = 32;  // one signed coefficient
  localparam int CFG_W      = 2 * COEF_W;
  localparam int CFG_REGS   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int DIGIT_BITS = 8;   // coefficient digit handled per cycle
  localparam int NDIG       = COEF_W / DIGIT_BITS;
  localparam int DIG_IDX_W  = 2;
  localparam int TERMS      = 10;  // products per sample
  localparam int TERM_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISP_PREV  = 3'd0,
    REG_DISP_INPUT = 3'd1,
    REG_VEL_PREV   = 3'd2,
    REG_VEL_INPUT  = 3'd3,
    REG_ACCEL      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SRC_DISP,
    SRC_VEL,
    SRC_PREV,
    SRC_CUR,
    SRC_ND,
    SRC_NV
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_SAT,
    ST_DONE
  } st_e;

  typedef struct packed {
    src_e     src;
    cfg_reg_e reg_idx;
    logic     hi;   // upper coefficient of the register
    logic     sub;  // product is subtracted
  } term_t;

  typedef struct packed {
    logic                 take;
    logic                 mac_en;
    logic                 acc_clr;
    logic                 lat_nd;
    logic                 lat_nv;
    logic                 lat_acc;
    logic                 commit;
    logic [TERM_W-1:0]    term;
    logic [DIG_IDX_W-1:0] digit;
  } sdofr_ctrl_t;

  // Order of the ten products: new displacement, new velocity, then acceleration.
  function automatic term_t term_info(input logic [TERM_W-1:0] t);
    term_t r;
    case (t)
      4'd0:    r = '{SRC_DISP, REG_DISP_PREV,  1'b0, 1'b0};
      4'd1:    r = '{SRC_VEL,  REG_DISP_PREV,  1'b1, 1'b0};
      4'd2:    r = '{SRC_PREV, REG_DISP_INPUT, 1'b0, 1'b1};
      4'd3:    r = '{SRC_CUR,  REG_DISP_INPUT, 1'b1, 1'b1};
      4'd4:    r = '{SRC_DISP, REG_VEL_PREV,   1'b0, 1'b0};
      4'd5:    r = '{SRC_VEL,  REG_VEL_PREV,   1'b1, 1'b0};
      4'd6:    r = '{SRC_PREV, REG_VEL_INPUT,  1'b0, 1'b1};
      4'd7:    r = '{SRC_CUR,  REG_VEL_INPUT,  1'b1, 1'b1};
      4'd8:    r = '{SRC_NV,   REG_ACCEL,      1'b0, 1'b1};
      4'd9:    r = '{SRC_ND,   REG_ACCEL,      1'b1, 1'b1};
      default: r = '{SRC_DISP, REG_DISP_PREV,  1'b0, 1'b0};
    endcase
    return r;
  endfunction

  // Last product of a sum that is then rounded and saturated.
  function automatic logic phase_end(input logic [TERM_W-1:0] t);
    return (t == TERM_W'(3)) || (t == TERM_W'(7)) || (t == TERM_W'(TERMS - 1));
  endfunction

endpackage

/* hdl/sdofr_mac.sv */
// Digit-serial multiply-accumulate: one 8-bit coefficient digit times a state word per cycle while en_i is high.
// Depends on sdofr_pkg.
module sdofr_mac import sdofr_pkg::*; #(
  parameter int STATE_BITS = 48,
  parameter int ACC_W      = 82
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clr_i,
  input  logic signed [STATE_BITS-1:0] operand_i,
  input  logic [DIGIT_BITS-1:0]        digit_i,
  input  logic                         top_i,    // most significant, signed digit
  input  logic [DIG_IDX_W-1:0]         idx_i,
  input  logic                         sub_i,
  output logic signed [ACC_W-1:0]      acc_o
);

  localparam int PP_W = STATE_BITS + DIGIT_BITS + 1;

  logic signed [DIGIT_BITS:0]  dig_x;
  logic signed [PP_W-1:0]      pp_d, pp_q;
  logic                        pv_q, sub_q;
  logic [DIG_IDX_W-1:0]        sh_q;
  logic signed [ACC_W-1:0]     ppx, term_x;
  logic signed [ACC_W-1:0]     acc_d, acc_q;

  assign dig_x = top_i ? {digit_i[DIGIT_BITS-1], digit_i} : {1'b0, digit_i};
  assign pp_d  = dig_x * operand_i;

  // The product is registered first; the wide add then works on the registered product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= pp_d;
    sh_q  <= idx_i;
    sub_q <= sub_i;
  end

  assign ppx    = ACC_W'(pp_q);
  assign term_x = ppx <<< (DIGIT_BITS * sh_q);

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = sub_q ? (acc_q - term_x) : (acc_q + term_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* hdl/sdofr_scale.sv */
// Rounds an exact sum of products by the coefficient fraction and saturates it to the state width.
// Depends on sdofr_pkg.
module sdofr_scale import sdofr_pkg::*; #(
  parameter int STATE_BITS     = 48,
  parameter int COEF_FRAC_BITS = 24,
  parameter int ACC_W          = 82
) (
  input  logic signed [ACC_W-1:0]      acc_i,
  output logic signed [STATE_BITS-1:0] res_o
);

  localparam int SH_W = ACC_W - COEF_FRAC_BITS;
  localparam logic [ACC_W-1:0] RND = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic [STATE_BITS-1:0] MAXV = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic [STATE_BITS-1:0] MINV = {1'b1, {(STATE_BITS-1){1'b0}}};

  logic [ACC_W-1:0] rnd;
  logic [SH_W-1:0]  sh;
  logic             ovf;

  assign rnd = acc_i + RND;
  assign sh  = rnd[ACC_W-1:COEF_FRAC_BITS];
  // In range only when every bit above the result's sign agrees with it.
  assign ovf = !((&sh[SH_W-1:STATE_BITS-1]) || !(|sh[SH_W-1:STATE_BITS-1]));

  always_comb begin
    if (ovf) begin
      res_o = sh[SH_W-1] ? MINV : MAXV;
    end else begin
      res_o = sh[STATE_BITS-1:0];
    end
  end

endmodule

/* hdl/sdofr_ctrl.sv */
// Sequencer: steps the ten coefficient products digit by digit and orders the result updates.
// Depends on sdofr_pkg.
module sdofr_ctrl import sdofr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        first_i,
  input  logic        out_free_i,
  output logic        s_ready_o,
  output sdofr_ctrl_t ctrl_o
);

  st_e                  state_q, state_d;
  logic [TERM_W-1:0]    term_q;
  logic [DIG_IDX_W-1:0] dig_q;
  logic                 last_dig;

  assign last_dig = (dig_q == DIG_IDX_W'(NDIG - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = first_i ? ST_DONE : ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_dig && phase_end(term_q)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_SAT;
      ST_SAT: begin
        state_d = (term_q == TERM_W'(TERMS)) ? ST_DONE : ST_MAC;
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o      = (state_q == ST_IDLE);
    ctrl_o.take    = (state_q == ST_IDLE) && s_valid_i;
    ctrl_o.mac_en  = (state_q == ST_MAC);
    ctrl_o.acc_clr = ctrl_o.take || (state_q == ST_SAT);
    ctrl_o.lat_nd  = (state_q == ST_SAT) && (term_q == TERM_W'(4));
    ctrl_o.lat_nv  = (state_q == ST_SAT) && (term_q == TERM_W'(8));
    ctrl_o.lat_acc = (state_q == ST_SAT) && (term_q == TERM_W'(TERMS));
    ctrl_o.commit  = (state_q == ST_DONE) && out_free_i;
    ctrl_o.term    = term_q;
    ctrl_o.digit   = dig_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.take) begin
        term_q <= '0;
        dig_q  <= '0;
      end else if (state_q == ST_MAC) begin
        dig_q <= dig_q + DIG_IDX_W'(1);
        if (last_dig) begin
          term_q <= term_q + TERM_W'(1);
        end
      end
    end
  end

  // A sum is only scaled after its last partial product has drained into the accumulator.
  a_sat_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SAT |-> $past(state_q) == ST_FLUSH)
    else $error("scaling without a drain cycle");

  a_flush_at_phase_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> $past(state_q) == ST_MAC && $past(last_dig)
                            && $past(phase_end(term_q)))
    else $error("drain started in the middle of a sum");

endmodule

/* hdl/sdof_oscillator_response_peaks.sv */
// Damped single-degree oscillator response with running displacement and acceleration peaks.
// Depends on sdofr_pkg, sdofr_ctrl, sdofr_mac and sdofr_scale.
//
// Usage: ground-acceleration samples arrive on the s_axis stream (tdata holds the sample,
// tuser the first-of-record flag); one result per sample leaves on the m_axis stream.
// The ten coefficients are written beforehand through cfg_we_i / cfg_idx_i / cfg_data_i,
// two signed Q-format coefficients per 64-bit register, only while the block is idle.
// A sample is taken only while the sequencer is idle, so a new one is not accepted before the
// last is finished: the single 8-bit by STATE_BITS multiply-accumulate runs ten products of
// four coefficient digits each, plus a drain and a scaling step for each of the three sums
// and a step each to take and to commit. A first-of-record sample skips the products; it
// clears displacement, velocity and peaks, keeps its sample as the previous input and goes
// out as an all-zero result. The output register lets the next sample be taken while a
// result waits; when the receiver stalls, the sequencer holds its finished sample until
// the output register is free. Reset clears the coefficients, the oscillator state and
// the peaks.
module sdof_oscillator_response_peaks import sdofr_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int STATE_BITS     = 48,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,   // sample
  input  logic                              s_axis_tuser,   // first
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((3*STATE_BITS+5)/8)*8-1:0] m_axis_tdata    // displacement, peak_disp, peak_accel
);

  localparam int ACC_W = STATE_BITS + COEF_W + 2;
  localparam int OUT_W = ((3 * STATE_BITS + 5) / 8) * 8;
  localparam int MAG_W = STATE_BITS - 1;

  sdofr_ctrl_t ctrl;
  term_t       tinfo;

  logic [CFG_W-1:0] cfg_q [CFG_REGS];

  logic signed [SAMPLE_BITS-1:0] cur_q, prev_q;
  logic                          first_q;
  logic signed [STATE_BITS-1:0]  disp_q, vel_q, nd_q, nv_q, accel_q;
  logic [MAG_W-1:0]              pk_d_q, pk_a_q;
  logic                          out_valid_q;
  logic signed [STATE_BITS-1:0]  out_disp_q;
  logic [MAG_W-1:0]              out_pk_d_q, out_pk_a_q;

  logic                          out_free;
  logic signed [STATE_BITS-1:0]  operand, sat_res;
  logic [CFG_W-1:0]              coef_reg;
  logic [COEF_W-1:0]             coef_half;
  logic [DIGIT_BITS-1:0]         digit;
  logic signed [ACC_W-1:0]       acc;
  logic [MAG_W-1:0]              mag_nd, mag_acc, mag_out;
  logic [MAG_W-1:0]              pk_d_new, pk_a_new;
  logic signed [STATE_BITS-1:0]  abs_nd, abs_acc, abs_out;

  assign out_free = !out_valid_q || m_axis_tready;

  sdofr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .first_i    (s_axis_tuser),
    .out_free_i (out_free),
    .s_ready_o  (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(CFG_REGS))) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Operand and coefficient digit for the product in progress.
  assign tinfo     = term_info(ctrl.term);
  assign coef_reg  = cfg_q[tinfo.reg_idx];
  assign coef_half = tinfo.hi ? coef_reg[CFG_W-1:COEF_W] : coef_reg[COEF_W-1:0];
  assign digit     = coef_half[ctrl.digit*DIGIT_BITS +: DIGIT_BITS];

  always_comb begin
    case (tinfo.src)
      SRC_DISP: operand = disp_q;
      SRC_VEL:  operand = vel_q;
      SRC_PREV: operand = STATE_BITS'(prev_q);
      SRC_CUR:  operand = STATE_BITS'(cur_q);
      SRC_ND:   operand = nd_q;
      SRC_NV:   operand = nv_q;
      default:  operand = disp_q;
    endcase
  end

  sdofr_mac #(
    .STATE_BITS (STATE_BITS),
    .ACC_W      (ACC_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (ctrl.mac_en),
    .clr_i     (ctrl.acc_clr),
    .operand_i (operand),
    .digit_i   (digit),
    .top_i     (ctrl.digit == DIG_IDX_W'(NDIG - 1)),
    .idx_i     (ctrl.digit),
    .sub_i     (tinfo.sub),
    .acc_o     (acc)
  );

  sdofr_scale #(
    .STATE_BITS     (STATE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_scale (
    .acc_i (acc),
    .res_o (sat_res)
  );

  // Magnitudes cap the most negative value at the largest positive one.
  assign abs_nd  = nd_q[STATE_BITS-1] ? -nd_q : nd_q;
  assign mag_nd  = abs_nd[STATE_BITS-1] ? {MAG_W{1'b1}} : abs_nd[MAG_W-1:0];
  assign abs_acc = accel_q[STATE_BITS-1] ? -accel_q : accel_q;
  assign mag_acc = abs_acc[STATE_BITS-1] ? {MAG_W{1'b1}} : abs_acc[MAG_W-1:0];

  assign pk_d_new = (mag_nd > pk_d_q) ? mag_nd : pk_d_q;
  assign pk_a_new = (mag_acc > pk_a_q) ? mag_acc : pk_a_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      cur_q   <= s_axis_tdata[SAMPLE_BITS-1:0];
      first_q <= s_axis_tuser;
    end
    if (ctrl.lat_nd) begin
      nd_q <= sat_res;
    end
    if (ctrl.lat_nv) begin
      nv_q <= sat_res;
    end
    if (ctrl.lat_acc) begin
      accel_q <= sat_res;
    end
    if (ctrl.commit) begin
      if (first_q) begin
        out_disp_q <= '0;
        out_pk_d_q <= '0;
        out_pk_a_q <= '0;
      end else begin
        out_disp_q <= nd_q;
        out_pk_d_q <= pk_d_new;
        out_pk_a_q <= pk_a_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      disp_q      <= '0;
      vel_q       <= '0;
      pk_d_q      <= '0;
      pk_a_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.commit) begin
        prev_q <= cur_q;
        if (first_q) begin
          disp_q <= '0;
          vel_q  <= '0;
          pk_d_q <= '0;
          pk_a_q <= '0;
        end else begin
          disp_q <= nd_q;
          vel_q  <= nv_q;
          pk_d_q <= pk_d_new;
          pk_a_q <= pk_a_new;
        end
      end
      if (ctrl.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_pk_a_q, out_pk_d_q, out_disp_q});

  assign abs_out = out_disp_q[STATE_BITS-1] ? -out_disp_q : out_disp_q;
  assign mag_out = abs_out[STATE_BITS-1] ? {MAG_W{1'b1}} : abs_out[MAG_W-1:0];

  // The running peak can never be below the magnitude of the displacement it goes out with.
  a_peak_covers_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pk_d_q >= mag_out)
    else $error("displacement peak below current displacement");

  a_first_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit && first_q |=> out_valid_q && out_disp_q == '0 && out_pk_d_q == '0
                                && out_pk_a_q == '0)
    else $error("first-of-record result not cleared");

endmodule
